>>> rtl/phsf_pkg.sv
// Shared types and constants of the pair hash slot finder.
// Holds the controller/datapath command and status structures, result codes and widths.
// Depends on nothing.
package phsf_pkg;

    localparam int DEF_TABLE_SLOTS = 1024;
    localparam int DEF_ID_BITS     = 16;

    localparam int HASH_W        = 32;
    localparam int CFG_W         = 11;
    localparam int STATUS_W      = 2;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam int MOD_STEP_BITS = 4;
    localparam int MOD_STEPS     = HASH_W / MOD_STEP_BITS;
    localparam int MOD_CNT_W     = $clog2(MOD_STEPS);

    localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RESET = CFG_W'(1024);
    localparam logic             REG_ACTIVE_SLOTS   = 1'b0;

    localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    typedef struct packed {
        logic clr;
        logic load;
        logic mul;
        logic hash;
        logic modstep;
        logic seek;
        logic cmp;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic mod_last;
        logic hit;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/phsf_ctrl.sv
// Controller of the pair hash slot finder: sequences clearing, hashing, reduction and probing.
// Depends on phsf_pkg for the command and status structures.
module phsf_ctrl
    import phsf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_HASH,
        S_MOD,
        S_SEEK,
        S_READ,
        S_CMP,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_HASH;
            end
            S_HASH: begin
                o_cmd.hash = 1'b1;
                n_state    = S_MOD;
            end
            S_MOD: begin
                o_cmd.modstep = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_SEEK;
                end
            end
            S_SEEK: begin
                o_cmd.seek = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_sts.hit ? S_FINISH : S_READ;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

>>> rtl/phsf_datapath.sv
// Datapath of the pair hash slot finder: pairing hash, iterative modulo, key store and probe compare.
// Depends on phsf_pkg for widths, result codes and the command and status structures.
module phsf_datapath
    import phsf_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int ID_BITS     = DEF_ID_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_cmd                               i_cmd,
    output t_sts                               o_sts,
    input  logic [CFG_W-1:0]                   i_active_slots,
    input  logic [ID_BITS-1:0]                 i_entity_a,
    input  logic [ID_BITS-1:0]                 i_entity_b,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [$clog2(TABLE_SLOTS)-1:0]     o_slot_index,
    output logic [STATUS_W-1:0]                o_status,
    output logic [$clog2(TABLE_SLOTS+1)-1:0]   o_probe_count
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int N_W    = $clog2(TABLE_SLOTS + 1);
    localparam int KEY_W  = 2 * ID_BITS;

    logic [KEY_W-1:0]     r_mem [TABLE_SLOTS];
    logic [KEY_W-1:0]     r_rd_data;
    logic [ID_BITS-1:0]   r_a;
    logic [ID_BITS-1:0]   r_b;
    logic [HASH_W-1:0]    r_sum;
    logic [HASH_W-1:0]    r_prod;
    logic [HASH_W-1:0]    r_hash;
    logic [N_W-1:0]       r_rem;
    logic [MOD_CNT_W-1:0] r_mcnt;
    logic [SLOT_W-1:0]    r_idx;
    logic [N_W-1:0]       r_probes;
    logic [SLOT_W-1:0]    r_res_slot;
    logic [STATUS_W-1:0]  r_res_status;
    logic [N_W-1:0]       r_res_probes;
    logic                 r_out_valid;
    logic [SLOT_W-1:0]    r_out_slot;
    logic [STATUS_W-1:0]  r_out_status;
    logic [N_W-1:0]       r_out_probes;

    logic [HASH_W-1:0]    cfg_ext;
    logic [N_W-1:0]       n_slots;
    logic [N_W-1:0]       n_rem;
    logic [ID_BITS-1:0]   k1;
    logic [ID_BITS-1:0]   k2;
    logic                 empty;
    logic                 match;
    logic                 full;
    logic [N_W-1:0]       probes_nxt;
    logic [N_W-1:0]       idx_inc;
    logic [SLOT_W-1:0]    idx_nxt;
    logic                 mem_we;
    logic [KEY_W-1:0]     mem_wdata;

    always_comb begin
        cfg_ext = HASH_W'(i_active_slots);
        if (cfg_ext == '0) begin
            n_slots = N_W'(1);
        end else if (cfg_ext > HASH_W'(TABLE_SLOTS)) begin
            n_slots = N_W'(TABLE_SLOTS);
        end else begin
            n_slots = N_W'(cfg_ext);
        end
    end

    always_comb begin
        logic [N_W:0]    t;
        logic [N_W-1:0]  rem_t;
        rem_t = r_rem;
        for (int k = 0; k < MOD_STEP_BITS; k++) begin
            t = {rem_t, r_hash[HASH_W-1-k]};
            if (t >= {1'b0, n_slots}) begin
                t = t - {1'b0, n_slots};
            end
            rem_t = t[N_W-1:0];
        end
        n_rem = rem_t;
    end

    assign k1         = r_rd_data[KEY_W-1:ID_BITS];
    assign k2         = r_rd_data[ID_BITS-1:0];
    assign empty      = (k1 == '0);
    assign match      = ((r_a == k1) && (r_b == k2)) || ((r_a == k2) && (r_b == k1));
    assign probes_nxt = r_probes + N_W'(1);
    assign full       = (probes_nxt == n_slots);
    assign idx_inc    = N_W'(r_idx) + N_W'(1);
    assign idx_nxt    = (idx_inc == n_slots) ? '0 : SLOT_W'(idx_inc);
    assign mem_we     = i_cmd.clr || (i_cmd.cmp && empty);
    assign mem_wdata  = i_cmd.clr ? '0 : {r_a, r_b};

    assign o_sts.clr_last = (r_idx == SLOT_W'(TABLE_SLOTS - 1));
    assign o_sts.mod_last = (r_mcnt == MOD_CNT_W'(MOD_STEPS - 1));
    assign o_sts.hit      = empty || match || full;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_idx <= o_sts.clr_last ? '0 : SLOT_W'(N_W'(r_idx) + N_W'(1));
            end else if (i_cmd.seek) begin
                r_idx <= SLOT_W'(r_rem);
            end else if (i_cmd.cmp && !o_sts.hit) begin
                r_idx <= idx_nxt;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a   <= i_entity_a;
            r_b   <= i_entity_b;
            r_sum <= HASH_W'(i_entity_a) + HASH_W'(i_entity_b);
        end
        if (i_cmd.mul) begin
            r_prod <= r_sum * (r_sum + HASH_W'(1));
        end
        if (i_cmd.hash) begin
            r_hash <= (r_prod >> 1) + HASH_W'(r_b);
            r_rem  <= '0;
            r_mcnt <= '0;
        end
        if (i_cmd.modstep) begin
            r_hash <= r_hash << MOD_STEP_BITS;
            r_rem  <= n_rem;
            r_mcnt <= r_mcnt + MOD_CNT_W'(1);
        end
        if (i_cmd.seek) begin
            r_probes <= '0;
        end
        if (i_cmd.cmp) begin
            if (empty) begin
                r_res_slot   <= r_idx;
                r_res_status <= STATUS_INSERTED;
                r_res_probes <= r_probes;
            end else if (match) begin
                r_res_slot   <= r_idx;
                r_res_status <= STATUS_FOUND;
                r_res_probes <= r_probes;
            end else if (full) begin
                r_res_slot   <= '0;
                r_res_status <= STATUS_FULL;
                r_res_probes <= probes_nxt;
            end else begin
                r_probes <= probes_nxt;
            end
        end
        if (i_cmd.emit) begin
            r_out_slot   <= r_res_slot;
            r_out_status <= r_res_status;
            r_out_probes <= r_res_probes;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot_index  = r_out_slot;
    assign o_status      = r_out_status;
    assign o_probe_count = r_out_probes;

endmodule

>>> rtl/pair_hash_slot_finder_top.sv
// A pair is loaded, paired into a hash, reduced by the iterative modulo and probed slot by
// slot in the single-port key store until its key, an empty slot or a full table is met.
// A new pair is accepted only once the previous one has been handed to the result register;
// a waiting result does not stop the next pair entering.
// Reset: synchronous, active low; afterwards a clearing pass writes every key slot, during
// which no pair is accepted. active_slots resets to 1024.
module pair_hash_slot_finder_top
    import phsf_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int ID_BITS     = DEF_ID_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [APB_ADDR_W-1:0]              paddr,
    input  logic [APB_DATA_W-1:0]              pwdata,
    output logic [APB_DATA_W-1:0]              prdata,
    output logic                               pready,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [ID_BITS-1:0]                 i_entity_a,
    input  logic [ID_BITS-1:0]                 i_entity_b,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [$clog2(TABLE_SLOTS)-1:0]     o_slot_index,
    output logic [STATUS_W-1:0]                o_status,
    output logic [$clog2(TABLE_SLOTS+1)-1:0]   o_probe_count
);

    logic [CFG_W-1:0] r_active_slots;
    logic             reg_sel;
    t_cmd             cmd;
    t_sts             sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_ACTIVE_SLOTS);
    assign prdata  = reg_sel ? APB_DATA_W'(r_active_slots) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_slots <= ACTIVE_SLOTS_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_active_slots <= pwdata[CFG_W-1:0];
        end
    end

    phsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    phsf_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_active_slots (r_active_slots),
        .i_entity_a     (i_entity_a),
        .i_entity_b     (i_entity_b),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_slot_index   (o_slot_index),
        .o_status       (o_status),
        .o_probe_count  (o_probe_count)
    );

`ifndef NO_ASSERTIONS
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("Input ready raised before the key store was cleared.");

    a_full_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STATUS_FULL)) |->
            ((o_slot_index == '0) && (o_probe_count != '0)))
        else $error("Table-full beat carries a slot or a zero probe count.");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STATUS_FULL)) |->
            (o_probe_count < ($clog2(TABLE_SLOTS+1))'(TABLE_SLOTS)))
        else $error("Found or inserted beat reports probes over the whole table.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_slot_index) && $stable(o_status) &&
             $stable(o_probe_count)))
        else $error("Result beat changed or dropped while it waited.");
`endif

endmodule
